[src/fprr_pkg.sv]
// Package with the operation codes and constants of the single-precision rounder.
package fprr_pkg;

  // Operation codes carried with every input word.
  typedef enum logic [1:0] {
    OP_BF16  = 2'd0,
    OP_F16   = 2'd1,
    OP_RNE   = 2'd2,
    OP_TRUNC = 2'd3
  } op_t;

  localparam int unsigned MANT_W = 5;

  // Kept mantissa bits after reset (tf32 width).
  localparam logic [MANT_W-1:0] MANT_BITS_RESET = 5'd10;
  // A mantissa width at or above this passes the input through.
  localparam logic [MANT_W-1:0] MANT_BITS_FULL  = 5'd23;

  localparam logic [7:0]  EXP_ALL_ONES = 8'hff;
  localparam logic [30:0] INF_MAG      = 31'h7f80_0000;

  // Single-precision exponent bounds for the f16 range.
  localparam logic [7:0] F16_EXP_OVF  = 8'd143;  // at or above: infinity
  localparam logic [7:0] F16_EXP_NORM = 8'd113;  // at or above: f16 normal
  localparam logic [7:0] F16_EXP_TINY = 8'd102;  // below: signed zero
  localparam logic [7:0] F16_SUB_BASE = 8'd126;  // shift = base - exponent
  localparam logic [7:0] F16_SUB_BIAS = 8'd103;  // exponent of 2^-24 grid

endpackage

[src/fp32_reduced_precision_rounder.sv]
// Throughput: one word per cycle while out_ready does not stall the result word;
// an input register and a result register with the rounding logic between them,
// so a new word enters while a result waits.
// The ready path runs combinationally from out_ready back to in_ready.
// Reset (rst_n low, synchronous) empties both stages and sets mantissa_bits to 10;
// cfg_ready is always high.
module fp32_reduced_precision_rounder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [31:0]                   in_input_bits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_result_bits,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fprr_pkg::MANT_W-1:0]   cfg_mantissa_bits
);
  import fprr_pkg::*;

  logic [MANT_W-1:0] mant_bits_r;
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [31:0]       s1_bits_r;
  logic              out_valid_r;
  logic [31:0]       out_result_r;
  logic [31:0]       round_res;
  logic              s1_adv;
  logic              in_acc;

  // Handshake: the result register frees when empty or taken.
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mant_bits_r <= MANT_BITS_RESET;
    end else if (cfg_valid) begin
      mant_bits_r <= cfg_mantissa_bits;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= op_t'(in_operation);
      s1_bits_r <= in_input_bits;
    end
    if (s1_adv && s1_valid_r) begin
      out_result_r <= round_res;
    end
  end

  // Rounding between the two registers.
  fprr_round u_round (
    .operation     (s1_op_r),
    .input_bits    (s1_bits_r),
    .mantissa_bits (mant_bits_r),
    .result_bits   (round_res)
  );

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_r;

endmodule

[src/fprr_round.sv]
// Combinational rounding of one single-precision word to the selected format.
module fprr_round (
  input  fprr_pkg::op_t                  operation,
  input  logic [31:0]                    input_bits,
  input  logic [fprr_pkg::MANT_W-1:0]    mantissa_bits,
  output logic [31:0]                    result_bits
);
  import fprr_pkg::*;

  logic        sign;
  logic [7:0]  expo;
  logic        special;

  logic [31:0] bf16_sum;
  logic [31:0] bf16_res;

  logic [4:0]  gen_sh;
  logic [31:0] gen_mask;
  logic [31:0] gen_sum;
  logic [31:0] rne_res;
  logic [31:0] trunc_res;
  logic        gen_pass;

  logic [12:0] nrm_rem;
  logic        nrm_inc;
  logic [17:0] nrm_sum;
  logic [31:0] nrm_res;

  logic [7:0]  sub_sh8;
  logic [4:0]  sub_sh;
  logic [23:0] sub_m;
  logic [24:0] sub_mask;
  logic [23:0] sub_rem;
  logic [23:0] sub_half;
  logic [9:0]  sub_hm0;
  logic        sub_inc;
  logic [10:0] sub_hm;
  logic [3:0]  sub_p;
  logic [23:0] sub_shift;
  logic [31:0] sub_res;

  logic [31:0] f16_res;

  assign sign    = input_bits[31];
  assign expo    = input_bits[30:23];
  assign special = (expo == EXP_ALL_ONES);

  // bf16: nearest even at bit 16.
  assign bf16_sum = input_bits + 32'h0000_7fff + {31'b0, input_bits[16]};
  assign bf16_res = special ? input_bits : {bf16_sum[31:16], 16'h0000};

  // Generic width: nearest even or truncation at a variable position.
  assign gen_pass  = special || (mantissa_bits >= MANT_BITS_FULL);
  assign gen_sh    = MANT_BITS_FULL - mantissa_bits;
  assign gen_mask  = (32'h1 << gen_sh) - 32'h1;
  assign gen_sum   = input_bits + (gen_mask >> 1) + {31'b0, input_bits[gen_sh]};
  assign rne_res   = gen_pass ? input_bits : (gen_sum & ~gen_mask);
  assign trunc_res = gen_pass ? input_bits : (input_bits & ~gen_mask);

  // f16 normal range: round at bit 13, carry may run into the exponent.
  assign nrm_rem = input_bits[12:0];
  assign nrm_inc = (nrm_rem > 13'h1000) || ((nrm_rem == 13'h1000) && input_bits[13]);
  assign nrm_sum = input_bits[30:13] + {17'b0, nrm_inc};
  assign nrm_res = (nrm_sum[17:10] >= F16_EXP_OVF) ? {sign, INF_MAG}
                                                   : {sign, nrm_sum, 13'b0};

  // f16 gradual underflow: round on the 2^-24 grid, then renormalize.
  assign sub_sh8  = F16_SUB_BASE - expo;
  assign sub_sh   = sub_sh8[4:0];
  assign sub_m    = {1'b1, input_bits[22:0]};
  assign sub_mask = (25'h1 << sub_sh) - 25'h1;
  assign sub_rem  = sub_m & sub_mask[23:0];
  assign sub_half = sub_mask[24:1] + 24'h1;
  assign sub_hm0  = 10'(sub_m >> sub_sh);
  assign sub_inc  = (sub_rem > sub_half) || ((sub_rem == sub_half) && sub_hm0[0]);
  assign sub_hm   = {1'b0, sub_hm0} + {10'b0, sub_inc};

  // Position of the leading one of the rounded grid count.
  always_comb begin
    sub_p = 4'd0;
    for (int i = 1; i < 11; i++) begin
      if (sub_hm[i]) begin
        sub_p = 4'(i);
      end
    end
  end

  assign sub_shift = {13'b0, sub_hm} << (5'd23 - {1'b0, sub_p});
  assign sub_res   = (sub_hm == 11'd0) ? {sign, 31'b0}
                   : {sign, F16_SUB_BIAS + {4'b0, sub_p}, sub_shift[22:0]};

  // f16 range selection.
  always_comb begin
    if (special) begin
      f16_res = input_bits;
    end else if (expo >= F16_EXP_OVF) begin
      f16_res = {sign, INF_MAG};
    end else if (expo >= F16_EXP_NORM) begin
      f16_res = nrm_res;
    end else if (expo < F16_EXP_TINY) begin
      f16_res = {sign, 31'b0};
    end else begin
      f16_res = sub_res;
    end
  end

  // Operation select.
  always_comb begin
    case (operation)
      OP_BF16:  result_bits = bf16_res;
      OP_F16:   result_bits = f16_res;
      OP_RNE:   result_bits = rne_res;
      OP_TRUNC: result_bits = trunc_res;
      default:  result_bits = input_bits;
    endcase
  end

endmodule

[src/fprr_checker.sv]
// Port-level checker for the rounder, bound to the top level.
module fprr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_bits
);

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_bits)))
    else $error("stalled result word changed");

  // With the result stalled, a word taken fills the input stage, so the
  // next word is taken only if the result leaves.
  a_fill_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && in_valid && in_ready) |=> (in_ready == out_ready))
    else $error("input taken with both stages full");

endmodule

bind fp32_reduced_precision_rounder fprr_checker u_fprr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_bits (out_result_bits)
);
